// ===== design/fee_pkg.sv =====
package fee_pkg;

	// Default sizes
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int RING_DEPTH_DEF    = 64;
	localparam int GEN_WIDTH_DEF     = 16;
	localparam int HANDLE_WIDTH_DEF  = 32;

	// Fixed field widths
	localparam int CMD_W = 2;
	localparam int IDX_W = 8;
	localparam int SEQ_W = 32;
	localparam int CAP_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Commands on the input channel
	localparam logic [CMD_W-1:0] CMD_MARK_LIVE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET_FREE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK_DEAD   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CHECK_VALID = 2'd3;

	// Classified operations handed from front to back
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_LIVE    = 3'd0; // push accepted, store handle
	localparam logic [OP_W-1:0] OP_FULL    = 3'd1; // push refused, ring full
	localparam logic [OP_W-1:0] OP_NOEVICT = 3'd2; // fresh allocation, nothing to do
	localparam logic [OP_W-1:0] OP_EMPTY   = 3'd3; // eviction wanted, ring empty
	localparam logic [OP_W-1:0] OP_EVICT   = 3'd4; // reclaim oldest live slot
	localparam logic [OP_W-1:0] OP_DEAD    = 3'd5; // clear slot, bump generation
	localparam logic [OP_W-1:0] OP_CHECK   = 3'd6; // compare generations

	// Table slots actually reachable by an element index
	function automatic int slot_count(input int te);
		return (te < (1 << IDX_W)) ? te : (1 << IDX_W);
	endfunction

	// Ring entries actually reachable with a capacity register value
	function automatic int ring_slots(input int rd);
		return (rd < ((1 << CAP_W) - 1)) ? rd : ((1 << CAP_W) - 1);
	endfunction

	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Queue word: {op, slot, handle, generation, present}
	function automatic int entry_width(input int slot_w, input int hw, input int gw);
		return OP_W + slot_w + hw + gw + 1;
	endfunction

endpackage

// ===== design/fee_ram.sv =====
module fee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = fee_pkg::addr_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/fee_queue.sv =====
module fee_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] data_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = data_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Store word
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("queue written while full");

endmodule

// ===== design/fee_front.sv =====
module fee_front #(
	parameter int TABLE_ENTRIES = fee_pkg::TABLE_ENTRIES_DEF,
	parameter int RING_DEPTH    = fee_pkg::RING_DEPTH_DEF,
	parameter int GEN_WIDTH     = fee_pkg::GEN_WIDTH_DEF,
	parameter int HANDLE_WIDTH  = fee_pkg::HANDLE_WIDTH_DEF,
	parameter int EW            = fee_pkg::entry_width(
		fee_pkg::addr_bits(fee_pkg::slot_count(TABLE_ENTRIES)), HANDLE_WIDTH, GEN_WIDTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [fee_pkg::CAP_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fee_pkg::CMD_W-1:0]  cmd,
	input  logic [fee_pkg::IDX_W-1:0]  element_index,
	input  logic [HANDLE_WIDTH-1:0]    element_handle,
	input  logic [fee_pkg::SEQ_W-1:0]  sequence_length,
	input  logic                       alloc_ok,
	input  logic [GEN_WIDTH-1:0]       node_generation,
	input  logic                       node_present,
	input  logic                       clearing,
	output logic                       q_push,
	output logic [EW-1:0]              q_wdata,
	input  logic                       q_full
);

	localparam int SLOTS      = fee_pkg::slot_count(TABLE_ENTRIES);
	localparam int SLOT_W     = fee_pkg::addr_bits(SLOTS);
	localparam int RING_SLOTS = fee_pkg::ring_slots(RING_DEPTH);
	localparam int RA_W       = fee_pkg::addr_bits(RING_SLOTS);
	localparam int CW         = fee_pkg::CAP_W;
	localparam int IDX_RANGE  = 1 << fee_pkg::IDX_W;

	localparam logic [CW-1:0] RING_MAX = CW'(RING_SLOTS);

	typedef logic [IDX_RANGE-1:0][SLOT_W-1:0] slot_tbl_t;

	// Index folding table, element index modulo table size
	function automatic slot_tbl_t build_slot_tbl();
		slot_tbl_t t;
		for (int i = 0; i < IDX_RANGE; i++) begin
			t[i] = SLOT_W'(i % TABLE_ENTRIES);
		end
		return t;
	endfunction

	localparam slot_tbl_t SLOT_TBL = build_slot_tbl();

	logic [CW-1:0]            cap_q;
	logic [CW-1:0]            cap_eff;
	logic [CW-1:0]            live_head_q;
	logic [CW-1:0]            evict_head_q;
	logic [CW-1:0]            ring_fill_q;
	logic                     live_red_q;
	logic                     evict_red_q;
	logic [CW-1:0]            red_cap_q;
	logic [CW-1:0]            live_nxt;
	logic [CW-1:0]            live_adv;
	logic [CW-1:0]            evict_nxt;
	logic [CW-1:0]            evict_adv;
	logic                     in_acc;
	logic [fee_pkg::OP_W-1:0] op_c;
	logic                     fresh;
	logic [SLOT_W-1:0]        slot_c;
	logic [SLOT_W-1:0]        ring_rdata;
	logic                     ring_we;
	logic                     ring_re;

	logic                     valid_s1;
	logic [fee_pkg::OP_W-1:0] op_s1;
	logic [SLOT_W-1:0]        slot_s1;
	logic [HANDLE_WIDTH-1:0]  handle_s1;
	logic [GEN_WIDTH-1:0]     ngen_s1;
	logic                     npres_s1;
	logic [SLOT_W-1:0]        push_slot;

	// Clamp capacity into the ring
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_q > RING_MAX) begin
			cap_eff = RING_MAX;
		end else begin
			cap_eff = cap_q;
		end
	end

	// Hold input while clearing, wrapping a head, or the stage cannot drain
	assign in_stall = clearing || live_red_q || evict_red_q || (valid_s1 && q_full);
	assign in_acc   = in_valid && !in_stall;
	assign slot_c   = SLOT_TBL[element_index];
	assign fresh    = (sequence_length < fee_pkg::SEQ_W'(cap_eff)) && alloc_ok;

	// Classify the command against ring occupancy
	always_comb begin
		unique case (cmd)
			fee_pkg::CMD_MARK_LIVE: begin
				op_c = (ring_fill_q >= cap_eff) ? fee_pkg::OP_FULL : fee_pkg::OP_LIVE;
			end
			fee_pkg::CMD_GET_FREE: begin
				if (fresh) begin
					op_c = fee_pkg::OP_NOEVICT;
				end else if (ring_fill_q == '0) begin
					op_c = fee_pkg::OP_EMPTY;
				end else begin
					op_c = fee_pkg::OP_EVICT;
				end
			end
			fee_pkg::CMD_MARK_DEAD:   op_c = fee_pkg::OP_DEAD;
			fee_pkg::CMD_CHECK_VALID: op_c = fee_pkg::OP_CHECK;
			default:                  op_c = fee_pkg::OP_CHECK;
		endcase
	end

	// Advance heads with one wrap; further wraps run in the reduce loop
	assign live_nxt  = live_head_q + CW'(1);
	assign live_adv  = (live_nxt >= cap_eff) ? (live_nxt - cap_eff) : live_nxt;
	assign evict_nxt = evict_head_q + CW'(1);
	assign evict_adv = (evict_nxt >= cap_eff) ? (evict_nxt - cap_eff) : evict_nxt;

	assign ring_we = in_acc && (op_c == fee_pkg::OP_LIVE);
	assign ring_re = in_acc && (op_c == fee_pkg::OP_EVICT);

	fee_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (RING_SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (live_head_q[RA_W-1:0]),
		.wdata (slot_c),
		.re    (ring_re),
		.raddr (evict_head_q[RA_W-1:0]),
		.rdata (ring_rdata)
	);

	// Ring control and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= fee_pkg::CAP_RESET;
			live_head_q  <= '0;
			evict_head_q <= '0;
			ring_fill_q  <= '0;
			live_red_q   <= 1'b0;
			evict_red_q  <= 1'b0;
			red_cap_q    <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (live_red_q) begin
				if (live_head_q >= red_cap_q) begin
					live_head_q <= live_head_q - red_cap_q;
				end else begin
					live_red_q <= 1'b0;
				end
			end
			if (evict_red_q) begin
				if (evict_head_q >= red_cap_q) begin
					evict_head_q <= evict_head_q - red_cap_q;
				end else begin
					evict_red_q <= 1'b0;
				end
			end
			if (ring_we) begin
				live_head_q <= live_adv;
				live_red_q  <= (live_adv >= cap_eff);
				red_cap_q   <= cap_eff;
				ring_fill_q <= ring_fill_q + CW'(1);
			end
			if (ring_re) begin
				evict_head_q <= evict_adv;
				evict_red_q  <= (evict_adv >= cap_eff);
				red_cap_q    <= cap_eff;
				ring_fill_q  <= ring_fill_q - CW'(1);
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Capture the classified word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1     <= op_c;
			slot_s1   <= slot_c;
			handle_s1 <= element_handle;
			ngen_s1   <= node_generation;
			npres_s1  <= node_present;
		end
	end

	// Eviction takes its slot from the ring read
	assign push_slot = (op_s1 == fee_pkg::OP_EVICT) ? ring_rdata : slot_s1;
	assign q_push    = valid_s1 && !q_full;
	assign q_wdata   = {op_s1, push_slot, handle_s1, ngen_s1, npres_s1};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_fill_q <= RING_MAX)
		else $error("live count beyond ring size");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && q_full) |=> (valid_s1 && $stable(op_s1) && $stable(slot_s1)))
		else $error("classified word lost while queue full");

endmodule

// ===== design/fee_back.sv =====
module fee_back #(
	parameter int TABLE_ENTRIES = fee_pkg::TABLE_ENTRIES_DEF,
	parameter int GEN_WIDTH     = fee_pkg::GEN_WIDTH_DEF,
	parameter int HANDLE_WIDTH  = fee_pkg::HANDLE_WIDTH_DEF,
	parameter int EW            = fee_pkg::entry_width(
		fee_pkg::addr_bits(fee_pkg::slot_count(TABLE_ENTRIES)), HANDLE_WIDTH, GEN_WIDTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      clearing,
	input  logic [EW-1:0]             q_rdata,
	input  logic                      q_empty,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic                      evicted,
	output logic [fee_pkg::IDX_W-1:0] victim_index,
	output logic [HANDLE_WIDTH-1:0]   victim_handle,
	output logic                      valid_res,
	output logic [GEN_WIDTH-1:0]      current_generation
);

	localparam int SLOTS  = fee_pkg::slot_count(TABLE_ENTRIES);
	localparam int SLOT_W = fee_pkg::addr_bits(SLOTS);

	// Word layout offsets
	localparam int GEN_LO  = 1;
	localparam int HDL_LO  = GEN_LO + GEN_WIDTH;
	localparam int SLOT_LO = HDL_LO + HANDLE_WIDTH;
	localparam int OP_LO   = SLOT_LO + SLOT_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RD    = 2'd1;
	localparam logic [1:0] ST_EX    = 2'd2;

	logic [1:0]               state_q;
	logic [SLOT_W-1:0]        clr_idx_q;
	logic                     out_free;
	logic                     exec;
	logic                     rd_en;

	logic [fee_pkg::OP_W-1:0] e_op;
	logic [SLOT_W-1:0]        e_slot;
	logic [HANDLE_WIDTH-1:0]  e_handle;
	logic [GEN_WIDTH-1:0]     e_gen;
	logic                     e_pres;

	logic [GEN_WIDTH-1:0]     gen_rd;
	logic [GEN_WIDTH-1:0]     gen_inc;
	logic [HANDLE_WIDTH-1:0]  hdl_rd;

	logic                     gen_we;
	logic [SLOT_W-1:0]        gen_waddr;
	logic [GEN_WIDTH-1:0]     gen_wdata;
	logic                     hdl_we;
	logic [HANDLE_WIDTH-1:0]  hdl_wdata;
	logic                     bump;

	logic                     status_c;
	logic                     evicted_c;
	logic [HANDLE_WIDTH-1:0]  vhandle_c;
	logic                     valid_c;
	logic [GEN_WIDTH-1:0]     gen_c;

	logic                     out_valid_q;
	logic                     status_q;
	logic                     evicted_q;
	logic [SLOT_W-1:0]        vidx_q;
	logic [HANDLE_WIDTH-1:0]  vhandle_q;
	logic                     valid_q;
	logic [GEN_WIDTH-1:0]     gen_q;

	// Split the queue word
	assign e_pres   = q_rdata[0];
	assign e_gen    = q_rdata[HDL_LO-1:GEN_LO];
	assign e_handle = q_rdata[SLOT_LO-1:HDL_LO];
	assign e_slot   = q_rdata[OP_LO-1:SLOT_LO];
	assign e_op     = q_rdata[EW-1:OP_LO];

	assign clearing = (state_q == ST_CLEAR);
	assign out_free = !out_valid_q || !out_stall;
	assign exec     = (state_q == ST_EX) && out_free;
	assign rd_en    = (state_q == ST_RD) && !q_empty;
	assign q_pop    = exec;
	assign gen_inc  = gen_rd + GEN_WIDTH'(1);

	// Work out the result and the table updates
	always_comb begin
		status_c  = 1'b0;
		evicted_c = 1'b0;
		vhandle_c = '0;
		valid_c   = 1'b0;
		gen_c     = '0;
		hdl_we    = 1'b0;
		hdl_wdata = '0;
		bump      = 1'b0;
		case (e_op)
			fee_pkg::OP_LIVE: begin
				hdl_we    = 1'b1;
				hdl_wdata = e_handle;
				gen_c     = gen_rd;
			end
			fee_pkg::OP_FULL: begin
				status_c = 1'b1;
				gen_c    = gen_rd;
			end
			fee_pkg::OP_EMPTY: begin
				status_c = 1'b1;
			end
			fee_pkg::OP_EVICT: begin
				evicted_c = 1'b1;
				vhandle_c = hdl_rd;
				hdl_we    = 1'b1;
				bump      = 1'b1;
				gen_c     = gen_inc;
			end
			fee_pkg::OP_DEAD: begin
				hdl_we = 1'b1;
				bump   = 1'b1;
				gen_c  = gen_inc;
			end
			fee_pkg::OP_CHECK: begin
				gen_c   = gen_rd;
				valid_c = e_pres && (gen_rd == e_gen);
			end
			default: begin
				status_c = 1'b0;
			end
		endcase
	end

	// Share the generation write port between clearing and bumps
	always_comb begin
		if (state_q == ST_CLEAR) begin
			gen_we    = 1'b1;
			gen_waddr = clr_idx_q;
			gen_wdata = '0;
		end else begin
			gen_we    = exec && bump;
			gen_waddr = e_slot;
			gen_wdata = gen_inc;
		end
	end

	fee_ram #(
		.WIDTH (GEN_WIDTH),
		.DEPTH (SLOTS)
	) u_gen (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (rd_en),
		.raddr (e_slot),
		.rdata (gen_rd)
	);

	fee_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (SLOTS)
	) u_handle (
		.clk   (clk),
		.we    (exec && hdl_we),
		.waddr (e_slot),
		.wdata (hdl_wdata),
		.re    (rd_en),
		.raddr (e_slot),
		.rdata (hdl_rd)
	);

	// Sequence clearing, read and execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SLOT_W'(1);
					if (clr_idx_q == LAST_SLOT) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (rd_en) begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					if (exec) begin
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q  <= status_c;
			evicted_q <= evicted_c;
			vidx_q    <= evicted_c ? e_slot : '0;
			vhandle_q <= vhandle_c;
			valid_q   <= valid_c;
			gen_q     <= gen_c;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign evicted            = evicted_q;
	assign victim_index       = fee_pkg::IDX_W'(vidx_q);
	assign victim_handle      = vhandle_q;
	assign valid_res          = valid_q;
	assign current_generation = gen_q;

	a_err_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(status_q && evicted_q))
		else $error("error result also reports an eviction");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!out_valid_q && !q_pop))
		else $error("work done during clearing pass");

endmodule

// ===== design/fifo_evicting_element_cache_core.sv =====
// A taken word passes the front stage register, the queue, the back-end RAM read and the
// output register before its result shows. The back end starts a new word only after the
// read-then-write pass over the generation and handle RAMs for the last one; a head wrap
// after a capacity decrease stalls input. Reset: asynchronous, active low; capacity
// returns to 64 and the ring empties. After reset, with input stalled, the generation RAM
// is cleared over its min(TABLE_ENTRIES, 256) slots; capacity writes are taken throughout.
module fifo_evicting_element_cache_core #(
	parameter int TABLE_ENTRIES = fee_pkg::TABLE_ENTRIES_DEF,
	parameter int RING_DEPTH    = fee_pkg::RING_DEPTH_DEF,
	parameter int GEN_WIDTH     = fee_pkg::GEN_WIDTH_DEF,
	parameter int HANDLE_WIDTH  = fee_pkg::HANDLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [fee_pkg::CAP_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [fee_pkg::CMD_W-1:0] cmd,
	input  logic [fee_pkg::IDX_W-1:0] element_index,
	input  logic [HANDLE_WIDTH-1:0]   element_handle,
	input  logic [fee_pkg::SEQ_W-1:0] sequence_length,
	input  logic                      alloc_ok,
	input  logic [GEN_WIDTH-1:0]      node_generation,
	input  logic                      node_present,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic                      evicted,
	output logic [fee_pkg::IDX_W-1:0] victim_index,
	output logic [HANDLE_WIDTH-1:0]   victim_handle,
	output logic                      valid_res,
	output logic [GEN_WIDTH-1:0]      current_generation
);

	localparam int SLOT_W = fee_pkg::addr_bits(fee_pkg::slot_count(TABLE_ENTRIES));
	localparam int EW     = fee_pkg::entry_width(SLOT_W, HANDLE_WIDTH, GEN_WIDTH);

	logic          clearing;
	logic          q_push;
	logic [EW-1:0] q_wdata;
	logic          q_full;
	logic          q_pop;
	logic [EW-1:0] q_rdata;
	logic          q_empty;

	// Classify and run the ring
	fee_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.RING_DEPTH    (RING_DEPTH),
		.GEN_WIDTH     (GEN_WIDTH),
		.HANDLE_WIDTH  (HANDLE_WIDTH),
		.EW            (EW)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.element_index   (element_index),
		.element_handle  (element_handle),
		.sequence_length (sequence_length),
		.alloc_ok        (alloc_ok),
		.node_generation (node_generation),
		.node_present    (node_present),
		.clearing        (clearing),
		.q_push          (q_push),
		.q_wdata         (q_wdata),
		.q_full          (q_full)
	);

	// Decouple front and back
	fee_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Update the element table and deliver results
	fee_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.GEN_WIDTH     (GEN_WIDTH),
		.HANDLE_WIDTH  (HANDLE_WIDTH),
		.EW            (EW)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.clearing           (clearing),
		.q_rdata            (q_rdata),
		.q_empty            (q_empty),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.evicted            (evicted),
		.victim_index       (victim_index),
		.victim_handle      (victim_handle),
		.valid_res          (valid_res),
		.current_generation (current_generation)
	);

endmodule
